FILE: design/sktc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sktc_pkg
// Shared types, codes and default sizes for the sorted key table.
// ----------------------------------------------------------------------------
package sktc_pkg;

    // default sizes
    localparam int DEF_ENTRIES    = 128;
    localparam int DEF_COUNT_BITS = 16;

    // fixed field widths
    localparam int KEY_W    = 44;
    localparam int OP_W     = 2;
    localparam int COPIES_W = 16;
    localparam int STATUS_W = 3;
    localparam int POS_W    = 7;
    localparam int CNT_OUT_W = 16;
    localparam int OCC_W    = 8;

    // operation codes
    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_DELETE = 2'd2,
        OP_TAKE   = 2'd3
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_PRESENT   = 3'd2,
        ST_FULL      = 3'd3,
        ST_NONE      = 3'd4
    } status_t;

    // engine states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_CHECK,
        S_SHIFT,
        S_PUT,
        S_DONE
    } state_t;

endpackage

FILE: design/sktc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sktc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sktc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: design/sorted_key_table_with_counts_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_table_with_counts_top
// Sorted record table with binary search, insert, delete and take-one.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid / in_stall) carries operation, key and copies.
//   One transaction is worked at a time; in_stall is high while the engine
//   is busy. A new transaction is taken while the previous result still
//   waits in the output register.
// - Output channel (out_valid / out_stall) returns one result per
//   transaction: status, position, total_count, available_count, occupancy.
// - All records sit in one RAM (key, total, available) with a registered
//   read. Each binary search probe passes through S_SEARCH and S_CMP, up to
//   ceil(log2(n+1)) probes for n records, then a fetch and a check.
// - Insert and delete move records one per cycle through the RAM port:
//   n-p moves for an insert at p, n-p-1 for a delete at p, plus a drain
//   that writes back the last record moved and, for insert, the new record.
// - The next transaction can be taken in the cycle after the result is loaded.
// - Reset clears the record count and the handshake state; RAM contents
//   are not cleared, since entries at or above the count never affect a result.
// - When the receiver stalls, the result holds in the output register and
//   the engine waits in its final state until the register frees up.
// ----------------------------------------------------------------------------
module sorted_key_table_with_counts_top #(
    parameter int ENTRIES    = sktc_pkg::DEF_ENTRIES,
    parameter int COUNT_BITS = sktc_pkg::DEF_COUNT_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [sktc_pkg::OP_W-1:0]      operation,
    input  logic [sktc_pkg::KEY_W-1:0]     key,
    input  logic [sktc_pkg::COPIES_W-1:0]  copies,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [sktc_pkg::STATUS_W-1:0]  status,
    output logic [sktc_pkg::POS_W-1:0]     position,
    output logic [sktc_pkg::CNT_OUT_W-1:0] total_count,
    output logic [sktc_pkg::CNT_OUT_W-1:0] available_count,
    output logic [sktc_pkg::OCC_W-1:0]     occupancy
);

    import sktc_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CW     = $clog2(ENTRIES + 1);
    localparam int CB     = COUNT_BITS;
    localparam int REC_W  = KEY_W + 2 * CB;
    localparam int CNT_WIDE = (CB > CNT_OUT_W) ? CB : CNT_OUT_W;
    localparam int CIN_WIDE = (CB > COPIES_W) ? CB : COPIES_W;
    localparam int POS_WIDE = (CW > POS_W) ? CW : POS_W;
    localparam int OCC_WIDE = (CW > OCC_W) ? CW : OCC_W;

    // engine state
    state_t            state_reg, state_next;
    op_t               op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [CB-1:0]     cp_reg, cp_next;
    logic [CW-1:0]     lo_reg, lo_next;
    logic [CW-1:0]     hi_reg, hi_next;
    logic [CW-1:0]     mid_reg, mid_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     moves_reg, moves_next;
    logic [IDX_W-1:0]  src_reg, src_next;
    logic [IDX_W-1:0]  dst_reg, dst_next;
    logic              pend_reg, pend_next;

    // result held until delivery
    status_t           res_status_reg, res_status_next;
    logic [CW-1:0]     res_pos_reg, res_pos_next;
    logic [CB-1:0]     res_tot_reg, res_tot_next;
    logic [CB-1:0]     res_av_reg, res_av_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [CW-1:0]     out_pos_reg, out_pos_next;
    logic [CB-1:0]     out_tot_reg, out_tot_next;
    logic [CB-1:0]     out_av_reg, out_av_next;
    logic [CW-1:0]     out_occ_reg, out_occ_next;

    // memory port
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [REC_W-1:0]  wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [REC_W-1:0]  rd_data;

    logic [KEY_W-1:0]  rd_key;
    logic [CB-1:0]     rd_tot;
    logic [CB-1:0]     rd_av;
    logic [CW-1:0]     mid_calc;
    logic              found;
    logic              in_acc;
    logic              out_free;
    logic [CIN_WIDE-1:0] copies_wide;
    logic [CNT_WIDE-1:0] tot_wide;
    logic [CNT_WIDE-1:0] av_wide;
    logic [POS_WIDE-1:0] pos_wide;
    logic [OCC_WIDE-1:0] occ_wide;

    // record storage
    sktc_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_key   = rd_data[REC_W-1 -: KEY_W];
    assign rd_tot   = rd_data[2*CB-1 -: CB];
    assign rd_av    = rd_data[CB-1:0];
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign found    = (lo_reg < count_reg) && (rd_key == key_reg);
    assign in_acc   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign copies_wide = CIN_WIDE'(copies);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                state_next = (lo_reg < hi_reg) ? S_CMP : S_CHECK;
            end
            S_CMP:
            begin
                state_next = S_SEARCH;
            end
            S_CHECK:
            begin
                state_next = S_DONE;
                if (found && op_reg == OP_DELETE)
                begin
                    state_next = S_SHIFT;
                end
                if (!found && op_reg == OP_INSERT && count_reg < CW'(ENTRIES))
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                if (moves_reg == '0 && !pend_reg)
                begin
                    state_next = (op_reg == OP_INSERT) ? S_PUT : S_DONE;
                end
            end
            S_PUT:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        cp_next         = cp_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        count_next      = count_reg;
        moves_next      = moves_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_tot_next    = res_tot_reg;
        res_av_next     = res_av_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_tot_next    = out_tot_reg;
        out_av_next     = out_av_reg;
        out_occ_next    = out_occ_reg;
        wr_en           = 1'b0;
        wr_addr         = lo_reg[IDX_W-1:0];
        wr_data         = {key_reg, cp_reg, cp_reg};
        rd_addr         = lo_reg[IDX_W-1:0];
        in_stall        = (state_reg != S_IDLE);

        // output register drains on transaction
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                // capture the incoming transaction
                if (in_acc)
                begin
                    op_next  = op_t'(operation);
                    key_next = key;
                    cp_next  = copies_wide[CB-1:0];
                    lo_next  = '0;
                    hi_next  = count_reg;
                end
            end
            S_SEARCH:
            begin
                // probe the middle entry, or fetch the final candidate
                if (lo_reg < hi_reg)
                begin
                    rd_addr  = mid_calc[IDX_W-1:0];
                    mid_next = mid_calc;
                end
            end
            S_CMP:
            begin
                if (rd_key < key_reg)
                begin
                    lo_next = mid_reg + CW'(1);
                end
                else
                begin
                    hi_next = mid_reg;
                end
            end
            S_CHECK:
            begin
                res_pos_next = lo_reg;
                res_tot_next = rd_tot;
                res_av_next  = rd_av;
                case (op_reg)
                    OP_INSERT:
                    begin
                        if (found)
                        begin
                            res_status_next = ST_PRESENT;
                        end
                        else if (count_reg >= CW'(ENTRIES))
                        begin
                            res_status_next = ST_FULL;
                            res_pos_next    = '0;
                            res_tot_next    = '0;
                            res_av_next     = '0;
                        end
                        else
                        begin
                            // make room: move entries p..n-1 up by one
                            res_status_next = ST_OK;
                            res_tot_next    = cp_reg;
                            res_av_next     = cp_reg;
                            moves_next      = count_reg - lo_reg;
                            src_next        = IDX_W'(count_reg - CW'(1));
                            pend_next       = 1'b0;
                        end
                    end
                    OP_LOOKUP:
                    begin
                        res_status_next = found ? ST_OK : ST_NOT_FOUND;
                    end
                    OP_DELETE:
                    begin
                        res_status_next = found ? ST_OK : ST_NOT_FOUND;
                        // close the gap: move entries p+1..n-1 down by one
                        moves_next = count_reg - lo_reg - CW'(1);
                        src_next   = IDX_W'(lo_reg + CW'(1));
                        pend_next  = 1'b0;
                    end
                    OP_TAKE:
                    begin
                        if (!found)
                        begin
                            res_status_next = ST_NOT_FOUND;
                        end
                        else if (rd_av == '0)
                        begin
                            res_status_next = ST_NONE;
                        end
                        else
                        begin
                            res_status_next = ST_OK;
                            res_av_next     = rd_av - CB'(1);
                            wr_en           = 1'b1;
                            wr_addr         = lo_reg[IDX_W-1:0];
                            wr_data         = {rd_key, rd_tot, rd_av - CB'(1)};
                        end
                    end
                    default:
                    begin
                        res_status_next = ST_NOT_FOUND;
                    end
                endcase
                if (!found && op_reg != OP_INSERT)
                begin
                    res_pos_next = '0;
                    res_tot_next = '0;
                    res_av_next  = '0;
                end
            end
            S_SHIFT:
            begin
                // write back the record read last cycle
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = dst_reg;
                    wr_data = rd_data;
                end
                // read the next record to move
                if (moves_reg != '0)
                begin
                    rd_addr    = src_reg;
                    pend_next  = 1'b1;
                    moves_next = moves_reg - CW'(1);
                    if (op_reg == OP_INSERT)
                    begin
                        dst_next = src_reg + IDX_W'(1);
                        src_next = src_reg - IDX_W'(1);
                    end
                    else
                    begin
                        dst_next = src_reg - IDX_W'(1);
                        src_next = src_reg + IDX_W'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg && op_reg == OP_DELETE)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            S_PUT:
            begin
                // place the new record at its sorted slot
                wr_en      = 1'b1;
                wr_addr    = lo_reg[IDX_W-1:0];
                wr_data    = {key_reg, cp_reg, cp_reg};
                count_next = count_reg + CW'(1);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    out_tot_next    = res_tot_reg;
                    out_av_next     = res_av_reg;
                    out_occ_next    = count_reg;
                end
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
            moves_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            moves_reg     <= moves_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        cp_reg         <= cp_next;
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        mid_reg        <= mid_next;
        src_reg        <= src_next;
        dst_reg        <= dst_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_tot_reg    <= res_tot_next;
        res_av_reg     <= res_av_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_tot_reg    <= out_tot_next;
        out_av_reg     <= out_av_next;
        out_occ_reg    <= out_occ_next;
    end

    // output fields, fitted to the port widths
    assign tot_wide = CNT_WIDE'(out_tot_reg);
    assign av_wide  = CNT_WIDE'(out_av_reg);
    assign pos_wide = POS_WIDE'(out_pos_reg);
    assign occ_wide = OCC_WIDE'(out_occ_reg);

    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign position        = pos_wide[POS_W-1:0];
    assign total_count     = tot_wide[CNT_OUT_W-1:0];
    assign available_count = av_wide[CNT_OUT_W-1:0];
    assign occupancy       = occ_wide[OCC_W-1:0];

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(ENTRIES))
        else $error("record count exceeds table size");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> state_reg == S_SEARCH)
        else $error("accepted transaction did not start a search");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result presented outside the final state");

    a_count_changes: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> ($past(op_reg) == OP_INSERT || $past(op_reg) == OP_DELETE))
        else $error("record count changed on lookup or take");

endmodule
